[hw/rtl/fgsh_pkg.sv]
// fire gate package: item types, sequencer states, register codes and constants
`timescale 1ns / 1ps
package fgsh_pkg;

    typedef struct packed {
        logic               control_on;
        logic               target_present;
        logic signed [15:0] pos_x_mm;
        logic signed [15:0] pos_y_mm;
        logic signed [15:0] spin_rate;
        logic [15:0]        flight_time;
        logic               aim_valid;
        logic signed [15:0] cmd_yaw;
        logic signed [15:0] gimbal_yaw;
        logic [15:0]        shot_speed;
        logic [2:0]         armor_count;
        logic [63:0]        armor_yaws;
    } t_in_item;

    typedef struct packed {
        logic        fire;
        logic        spin_mode;
        logic [15:0] mean_speed;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_SPIN, S_CORDIC, S_LANE, S_MUL, S_RATIO, S_TOL, S_DECIDE,
        S_PUSH_RD, S_PUSH_WR, S_DIV_GO, S_DIV_WAIT, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        M_LHS, M_RMIN_A, M_RMIN_B, M_RMAX_A, M_RMAX_B, M_XX, M_YY, M_JR
    } t_mul_step;

    typedef enum logic [2:0] {
        REG_NEAR_TOL, REG_FAR_TOL, REG_JUDGE_RANGE, REG_AUTO_FIRE,
        REG_SPIN_ENTER, REG_SPIN_EXIT, REG_RATIO_MIN, REG_RATIO_MAX
    } t_reg_idx;

    typedef struct packed {
        logic start;
    } t_unit_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

    localparam int CORDIC_ITERS = 16;
    localparam logic signed [17:0] PI_Q12     = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;
    localparam logic signed [20:0] PI_Q16     = 21'sd205887;
    localparam logic [19:0]        RATIO_SCALE = 20'd640000;

    function automatic logic [15:0] cordic_atan(input logic [3:0] i);
        logic [15:0] v;
        case (i)
            4'd0:    v = 16'd51472;
            4'd1:    v = 16'd30386;
            4'd2:    v = 16'd16055;
            4'd3:    v = 16'd8150;
            4'd4:    v = 16'd4091;
            4'd5:    v = 16'd2047;
            4'd6:    v = 16'd1024;
            4'd7:    v = 16'd512;
            4'd8:    v = 16'd256;
            4'd9:    v = 16'd128;
            4'd10:   v = 16'd64;
            4'd11:   v = 16'd32;
            4'd12:   v = 16'd16;
            4'd13:   v = 16'd8;
            4'd14:   v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/fgsh_in_if.sv]
// aiming frame input channel
`timescale 1ns / 1ps
interface fgsh_in_if;
    import fgsh_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/fgsh_out_if.sv]
// fire decision output channel
`timescale 1ns / 1ps
interface fgsh_out_if;
    import fgsh_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/fgsh_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
module fgsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/fgsh_cordic.sv]
// iterative cordic vectoring unit for the target centre yaw
`timescale 1ns / 1ps
module fgsh_cordic (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  fgsh_pkg::t_unit_ctl       i_ctl,
    input  logic signed [15:0]        i_x,
    input  logic signed [15:0]        i_y,
    output fgsh_pkg::t_unit_sts       o_sts,
    output logic signed [15:0]        o_angle
);
    import fgsh_pkg::*;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [3:0]         r_iter, n_iter;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic signed [20:0] r_z, n_z;
    logic signed [15:0] r_angle, n_angle;
    logic signed [33:0] c_x0, c_y0, c_xs, c_ys;
    logic signed [20:0] c_at, c_zr;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_iter  = r_iter;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_angle = r_angle;
        c_x0    = 34'(i_x) <<< 14;
        c_y0    = 34'(i_y) <<< 14;
        c_xs    = r_x >>> r_iter;
        c_ys    = r_y >>> r_iter;
        c_at    = 21'(cordic_atan(r_iter));
        c_zr    = 21'sd0;
        if (i_ctl.start) begin
            if (i_x == 16'sd0 && i_y == 16'sd0) begin
                n_angle = 16'sd0;
                n_done  = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_iter = 4'd0;
                if (i_x < 16'sd0) begin
                    n_x = -c_x0;
                    n_y = -c_y0;
                    n_z = (i_y >= 16'sd0) ? PI_Q16 : -PI_Q16;
                end else begin
                    n_x = c_x0;
                    n_y = c_y0;
                    n_z = 21'sd0;
                end
            end
        end else if (r_busy) begin
            if (r_y > 34'sd0) begin
                n_x = r_x + c_ys;
                n_y = r_y - c_xs;
                n_z = r_z + c_at;
            end else begin
                n_x = r_x - c_ys;
                n_y = r_y + c_xs;
                n_z = r_z - c_at;
            end
            n_iter = r_iter + 4'd1;
            if (r_iter == 4'(CORDIC_ITERS - 1)) begin
                c_zr    = (n_z + 21'sd8) >>> 4;
                n_angle = c_zr[15:0];
                n_busy  = 1'b0;
                n_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_iter  <= n_iter;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_angle <= n_angle;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_angle    = r_angle;
endmodule

[hw/rtl/fgsh_div.sv]
// restoring divider, one quotient bit per cycle, for the window mean
`timescale 1ns / 1ps
module fgsh_div #(
    parameter int NW = 20,
    parameter int DW = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fgsh_pkg::t_unit_ctl i_ctl,
    input  logic [NW-1:0]       i_num,
    input  logic [DW-1:0]       i_den,
    output fgsh_pkg::t_unit_sts o_sts,
    output logic [NW-1:0]       o_quo
);
    import fgsh_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_quo, n_quo;
    logic [DW:0]   c_trial;
    logic          c_ge;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        c_trial = {r_rem, r_quo[NW-1]};
        c_ge    = c_trial >= {1'b0, i_den};
        if (i_ctl.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NW);
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = c_ge ? DW'(c_trial - {1'b0, i_den}) : DW'(c_trial);
            n_quo = {r_quo[NW-2:0], c_ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;
endmodule

[hw/rtl/fire_gate_with_spin_hysteresis_top.sv]
// fire gate with spin hysteresis: sequencer, shared multiplier, window and units
//
//  channel  dir  handshake          payload
//  i_in     in   valid/ready        t_in_item (aiming frame)
//  o_out    out  valid/ready        t_out_item (fire, spin_mode, mean_speed)
//  i_cfg_*  in   write enable only  register index, 16-bit data
//
//  one frame at a time; the spin path takes 16 cordic steps and a handover, one step per armour
//  lane and five multiplies; a push into the window reads the oldest entry before it writes it,
//  an empty window skips the divide, and otherwise the divider takes
//  NW = 16 + clog2(WINDOW_DEPTH + 1) divide steps
//  a finished result waits in the output register while the next frame is taken; a result
//  still not taken holds the sequencer in its output state
//  reset is synchronous and clears flags, counters and the speed window state
`timescale 1ns / 1ps
module fire_gate_with_spin_hysteresis_top #(
    parameter int WINDOW_DEPTH = 8,
    parameter int EXIT_FRAMES  = 5,
    parameter int MAX_ARMORS   = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fgsh_in_if.sink     i_in,
    fgsh_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import fgsh_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = 16 + FW;
    localparam int LW = (MAX_ARMORS > 1) ? $clog2(MAX_ARMORS) : 1;

    // configuration
    logic [14:0] r_near_tol, r_far_tol, r_judge, r_enter, r_exit_rate;
    logic        r_auto;
    logic [15:0] r_rmin_cfg, r_rmax_cfg;

    t_state             r_state, n_state;
    t_in_item           r_item, n_item;
    logic               r_fire, n_fire;
    logic               r_spinning, n_spinning;
    logic [7:0]         r_exit, n_exit;
    logic signed [15:0] r_prev_cmd, n_prev_cmd;
    logic [FW-1:0]      r_fill, n_fill;
    logic [AW-1:0]      r_head, n_head;
    logic [15:0]        r_last, n_last;
    logic [SW-1:0]      r_sum, n_sum;
    logic signed [15:0] r_center, n_center;
    logic [LW-1:0]      r_lane, n_lane;
    logic               r_found, n_found;
    logic [14:0]        r_best, n_best;
    t_mul_step          r_mstep, n_mstep;
    logic [47:0]        r_lhs, n_lhs, r_rmin, n_rmin, r_rmax, n_rmax, r_tmp, n_tmp;
    logic [15:0]        r_mean, n_mean;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic               c_gate, c_spin_nxt;
    logic [7:0]         c_exit_nxt;
    logic signed [16:0] c_w17;
    logic [15:0]        c_aw;
    logic [2:0]         c_cnt;
    logic signed [15:0] c_armor;
    logic signed [17:0] c_d;
    logic [14:0]        c_ad;
    logic               c_coming;
    logic signed [16:0] c_step17, c_err17;
    logic [16:0]        c_step, c_err;
    logic [14:0]        c_tol;
    logic [15:0]        c_ax, c_ay;
    logic [31:0]        m_a;
    logic [19:0]        m_b;
    logic [51:0]        m_p;

    t_unit_ctl          c_cordic_ctl, c_div_ctl;
    t_unit_sts          w_cordic_sts, w_div_sts;
    logic signed [15:0] w_angle;
    logic [SW-1:0]      w_quo;
    logic               c_we;
    logic [15:0]        w_rdata;

    fgsh_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (c_cordic_ctl),
        .i_x     (r_item.pos_x_mm),
        .i_y     (r_item.pos_y_mm),
        .o_sts   (w_cordic_sts),
        .o_angle (w_angle)
    );

    fgsh_div #(.NW(SW), .DW(FW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (c_div_ctl),
        .i_num   (r_sum),
        .i_den   (r_fill),
        .o_sts   (w_div_sts),
        .o_quo   (w_quo)
    );

    fgsh_ram #(.WIDTH(16), .DEPTH(WINDOW_DEPTH), .AW(AW)) u_window (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (r_head),
        .i_wdata (r_item.shot_speed),
        .i_raddr (r_head),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_tol  <= '0;
            r_far_tol   <= '0;
            r_judge     <= '0;
            r_auto      <= 1'b0;
            r_enter     <= '0;
            r_exit_rate <= '0;
            r_rmin_cfg  <= '0;
            r_rmax_cfg  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_NEAR_TOL:    r_near_tol  <= i_cfg_data[14:0];
                REG_FAR_TOL:     r_far_tol   <= i_cfg_data[14:0];
                REG_JUDGE_RANGE: r_judge     <= i_cfg_data[14:0];
                REG_AUTO_FIRE:   r_auto      <= i_cfg_data[0];
                REG_SPIN_ENTER:  r_enter     <= i_cfg_data[14:0];
                REG_SPIN_EXIT:   r_exit_rate <= i_cfg_data[14:0];
                REG_RATIO_MIN:   r_rmin_cfg  <= i_cfg_data;
                REG_RATIO_MAX:   r_rmax_cfg  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-frame helpers
    always_comb begin
        c_gate = r_item.control_on && r_item.target_present && r_auto;
        c_w17  = {r_item.spin_rate[15], r_item.spin_rate};
        c_aw   = c_w17[16] ? 16'(-c_w17) : c_w17[15:0];
        c_cnt  = (r_item.armor_count > 3'(MAX_ARMORS)) ? 3'(MAX_ARMORS) : r_item.armor_count;

        c_spin_nxt = r_spinning;
        c_exit_nxt = r_exit;
        if (r_spinning) begin
            if (c_aw < {1'b0, r_exit_rate}) begin
                c_exit_nxt = r_exit + 8'd1;
                if (c_exit_nxt >= 8'(EXIT_FRAMES)) begin
                    c_spin_nxt = 1'b0;
                    c_exit_nxt = 8'd0;
                end
            end else begin
                c_exit_nxt = 8'd0;
            end
        end else if (c_aw > {1'b0, r_enter}) begin
            c_spin_nxt = 1'b1;
            c_exit_nxt = 8'd0;
        end

        // armour delta wrapped into (-pi, pi]
        c_armor = r_item.armor_yaws[{r_lane, 4'd0} +: 16];
        c_d     = 18'(c_armor) - 18'(r_center);
        if (c_d > PI_Q12)   c_d = c_d - TWO_PI_Q12;
        if (c_d > PI_Q12)   c_d = c_d - TWO_PI_Q12;
        if (c_d <= -PI_Q12) c_d = c_d + TWO_PI_Q12;
        if (c_d <= -PI_Q12) c_d = c_d + TWO_PI_Q12;
        c_ad     = (c_d < 18'sd0) ? 15'(-c_d) : 15'(c_d);
        c_coming = (r_item.spin_rate > 16'sd0 && c_d < 18'sd0)
                || (r_item.spin_rate < 16'sd0 && c_d > 18'sd0);

        c_step17 = {r_prev_cmd[15], r_prev_cmd} - {r_item.cmd_yaw[15], r_item.cmd_yaw};
        c_err17  = {r_item.gimbal_yaw[15], r_item.gimbal_yaw}
                 - {r_item.cmd_yaw[15], r_item.cmd_yaw};
        c_step   = c_step17[16] ? 17'(-c_step17) : 17'(c_step17);
        c_err    = c_err17[16] ? 17'(-c_err17) : 17'(c_err17);
        c_tol    = (r_lhs > r_rmin) ? r_far_tol : r_near_tol;

        c_ax = r_item.pos_x_mm[15] ? 16'(-r_item.pos_x_mm) : r_item.pos_x_mm;
        c_ay = r_item.pos_y_mm[15] ? 16'(-r_item.pos_y_mm) : r_item.pos_y_mm;
    end

    // shared multiplier
    always_comb begin
        case (r_mstep)
            M_LHS:    begin m_a = 32'(r_best);     m_b = RATIO_SCALE;           end
            M_RMIN_A: begin m_a = 32'(r_rmin_cfg); m_b = 20'(c_aw);             end
            M_RMIN_B: begin m_a = r_tmp[31:0];     m_b = 20'(r_item.flight_time); end
            M_RMAX_A: begin m_a = 32'(r_rmax_cfg); m_b = 20'(c_aw);             end
            M_RMAX_B: begin m_a = r_tmp[31:0];     m_b = 20'(r_item.flight_time); end
            M_XX:     begin m_a = 32'(c_ax);       m_b = 20'(c_ax);             end
            M_YY:     begin m_a = 32'(c_ay);       m_b = 20'(c_ay);             end
            M_JR:     begin m_a = 32'(r_judge);    m_b = 20'(r_judge);          end
            default:  begin m_a = '0;              m_b = '0;                    end
        endcase
        m_p = 52'(m_a) * 52'(m_b);
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_fire      = r_fire;
        n_spinning  = r_spinning;
        n_exit      = r_exit;
        n_prev_cmd  = r_prev_cmd;
        n_fill      = r_fill;
        n_head      = r_head;
        n_last      = r_last;
        n_sum       = r_sum;
        n_center    = r_center;
        n_lane      = r_lane;
        n_found     = r_found;
        n_best      = r_best;
        n_mstep     = r_mstep;
        n_lhs       = r_lhs;
        n_rmin      = r_rmin;
        n_rmax      = r_rmax;
        n_tmp       = r_tmp;
        n_mean      = r_mean;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        c_cordic_ctl.start = 1'b0;
        c_div_ctl.start    = 1'b0;
        c_we        = 1'b0;
        i_in.ready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_item  = i_in.data;
                    n_state = S_SPIN;
                end
            end
            S_SPIN: begin
                n_fire = 1'b0;
                if (!c_gate) begin
                    n_state = S_DIV_GO;
                end else begin
                    n_spinning = c_spin_nxt;
                    n_exit     = c_exit_nxt;
                    if (c_spin_nxt) begin
                        if (r_item.flight_time == 16'd0 || c_cnt == 3'd0) begin
                            n_state = S_DECIDE;
                        end else begin
                            c_cordic_ctl.start = 1'b1;
                            n_state = S_CORDIC;
                        end
                    end else begin
                        n_mstep = M_XX;
                        n_state = S_MUL;
                    end
                end
            end
            S_CORDIC: begin
                if (w_cordic_sts.done) begin
                    n_center = w_angle;
                    n_lane   = '0;
                    n_found  = 1'b0;
                    n_state  = S_LANE;
                end
            end
            S_LANE: begin
                if (3'(r_lane) < c_cnt && c_coming && (!r_found || c_ad < r_best)) begin
                    n_best  = c_ad;
                    n_found = 1'b1;
                end
                if (r_lane == LW'(MAX_ARMORS - 1)) begin
                    n_mstep = M_LHS;
                    n_state = n_found ? S_MUL : S_DECIDE;
                end else begin
                    n_lane = r_lane + 1'b1;
                end
            end
            S_MUL: begin
                n_mstep = t_mul_step'(r_mstep + 3'd1);
                case (r_mstep)
                    M_LHS:    n_lhs  = m_p[47:0];
                    M_RMIN_A: n_tmp  = m_p[47:0];
                    M_RMIN_B: n_rmin = m_p[47:0];
                    M_RMAX_A: n_tmp  = m_p[47:0];
                    M_RMAX_B: begin
                        n_rmax  = m_p[47:0];
                        n_state = S_RATIO;
                    end
                    M_XX:     n_lhs  = m_p[47:0];
                    M_YY:     n_lhs  = r_lhs + m_p[47:0];
                    M_JR: begin
                        n_rmin  = m_p[47:0];
                        n_state = S_TOL;
                    end
                    default: ;
                endcase
            end
            S_RATIO: begin
                n_fire  = (r_lhs >= r_rmin) && (r_lhs <= r_rmax);
                n_state = S_DECIDE;
            end
            S_TOL: begin
                n_fire  = (c_step < {1'b0, c_tol, 1'b0}) && (c_err < {2'b0, c_tol})
                       && r_item.aim_valid;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_prev_cmd = r_item.cmd_yaw;
                if (r_fire && !(r_fill != '0 && r_item.shot_speed == r_last)) begin
                    n_state = S_PUSH_RD;
                end else begin
                    n_state = S_DIV_GO;
                end
            end
            S_PUSH_RD: begin
                n_state = S_PUSH_WR;
            end
            S_PUSH_WR: begin
                c_we  = 1'b1;
                n_sum = r_sum + SW'(r_item.shot_speed)
                      - ((r_fill == FW'(WINDOW_DEPTH)) ? SW'(w_rdata) : SW'(0));
                n_head = (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
                if (r_fill != FW'(WINDOW_DEPTH)) begin
                    n_fill = r_fill + 1'b1;
                end
                n_last  = r_item.shot_speed;
                n_state = S_DIV_GO;
            end
            S_DIV_GO: begin
                if (r_fill == '0) begin
                    n_mean  = 16'd0;
                    n_state = S_OUT;
                end else begin
                    c_div_ctl.start = 1'b1;
                    n_state = S_DIV_WAIT;
                end
            end
            S_DIV_WAIT: begin
                if (w_div_sts.done) begin
                    n_mean  = w_quo[15:0];
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out.fire       = r_fire;
                    n_out.spin_mode  = r_spinning;
                    n_out.mean_speed = r_mean;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spinning  <= 1'b0;
            r_exit      <= 8'd0;
            r_prev_cmd  <= 16'sd0;
            r_fill      <= '0;
            r_head      <= '0;
            r_last      <= 16'd0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_spinning  <= n_spinning;
            r_exit      <= n_exit;
            r_prev_cmd  <= n_prev_cmd;
            r_fill      <= n_fill;
            r_head      <= n_head;
            r_last      <= n_last;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_item   <= n_item;
        r_fire   <= n_fire;
        r_center <= n_center;
        r_lane   <= n_lane;
        r_found  <= n_found;
        r_best   <= n_best;
        r_mstep  <= n_mstep;
        r_lhs    <= n_lhs;
        r_rmin   <= n_rmin;
        r_rmax   <= n_rmax;
        r_tmp    <= n_tmp;
        r_mean   <= n_mean;
        r_out    <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_DEPTH))
        else $error("window fill above depth");
    a_exit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_spinning |-> r_exit == 8'd0)
        else $error("exit frames counted outside spin mode");
    a_exit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exit < 8'(EXIT_FRAMES))
        else $error("exit frame count reached limit");
    a_push_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_we |=> r_state == S_DIV_GO && r_fill != '0)
        else $error("window write not followed by mean update");
`endif
endmodule

[tb/fire_gate_with_spin_hysteresis_top_tb.sv]
// testbench for the fire gate: random and directed aiming frames against a predicting scoreboard
`timescale 1ns / 1ps
module fire_gate_with_spin_hysteresis_top_tb;
    import fgsh_pkg::*;

    localparam int WIN_DEPTH  = 8;
    localparam int EXIT_COUNT = 5;
    localparam int LANES      = 4;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int EXP_SLOTS  = 64;

    class fire_scoreboard;
        int unsigned regs[8];
        bit          spinning;
        int          exit_cnt;
        int          prev_cmd;
        bit [15:0]   speeds[WIN_DEPTH];
        int          fill;
        int          head;
        bit [15:0]   last_speed;
        t_out_item   expected[EXP_SLOTS];
        int          n_noted;
        int          n_checked;
        int          errors;
        int          atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                      256, 128, 64, 32, 16, 8, 4, 2};

        function void set_reg(t_reg_idx idx, bit [15:0] val);
            regs[idx] = (idx == REG_AUTO_FIRE) ? val[0] :
                        (idx == REG_RATIO_MIN || idx == REG_RATIO_MAX) ? val : val[14:0];
        endfunction

        function int outstanding();
            return n_noted - n_checked;
        endfunction

        function int centre_angle(int xi, int yi);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            x = longint'(xi) * 16384;
            y = longint'(yi) * 16384;
            z = 0;
            if (xi == 0 && yi == 0) return 0;
            if (xi < 0) begin
                z = (yi >= 0) ? 205887 : -205887;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 16; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x += ys; y -= xs; z += atan_tab[i];
                end else begin
                    x -= ys; y += xs; z -= atan_tab[i];
                end
            end
            return int'((z + 8) >>> 4);
        endfunction

        function bit spin_shot(t_in_item it, int w);
            int     cnt;
            int     ctr;
            int     d;
            int     best;
            bit     found;
            longint lhs;
            longint rhs;
            cnt = it.armor_count;
            found = 0;
            best = 0;
            if (it.flight_time == 0) return 0;
            if (cnt > LANES) cnt = LANES;
            ctr = centre_angle($signed(it.pos_x_mm), $signed(it.pos_y_mm));
            for (int i = 0; i < cnt; i++) begin
                d = int'($signed(it.armor_yaws[16*i +: 16])) - ctr;
                while (d > 12868) d -= 25736;
                while (d <= -12868) d += 25736;
                if (((w > 0 && d < 0) || (w < 0 && d > 0)) && (!found || (d < 0 ? -d : d) < best)) begin
                    best = d < 0 ? -d : d;
                    found = 1;
                end
            end
            if (!found) return 0;
            lhs = longint'(best) * 640000;
            rhs = longint'(w < 0 ? -w : w) * longint'(it.flight_time);
            return lhs >= longint'(regs[REG_RATIO_MIN]) * rhs &&
                   lhs <= longint'(regs[REG_RATIO_MAX]) * rhs;
        endfunction

        function void note_frame(t_in_item it);
            t_out_item exp_item;
            int        w;
            int        aw;
            int        cmd;
            int        tol;
            int        step;
            int        err;
            longint    x;
            longint    y;
            longint    sum;
            bit        fire;
            fire = 0;
            if (it.control_on && it.target_present && regs[REG_AUTO_FIRE] != 0) begin
                w = $signed(it.spin_rate);
                aw = w < 0 ? -w : w;
                cmd = $signed(it.cmd_yaw);
                if (spinning) begin
                    if (aw < regs[REG_SPIN_EXIT]) begin
                        exit_cnt++;
                        if (exit_cnt >= EXIT_COUNT) begin
                            spinning = 0;
                            exit_cnt = 0;
                        end
                    end else exit_cnt = 0;
                end else if (aw > regs[REG_SPIN_ENTER]) begin
                    spinning = 1;
                    exit_cnt = 0;
                end
                if (spinning) fire = spin_shot(it, w);
                else begin
                    x = $signed(it.pos_x_mm);
                    y = $signed(it.pos_y_mm);
                    tol = (x * x + y * y > longint'(regs[REG_JUDGE_RANGE]) * regs[REG_JUDGE_RANGE])
                          ? regs[REG_FAR_TOL] : regs[REG_NEAR_TOL];
                    step = prev_cmd - cmd;
                    err = int'($signed(it.gimbal_yaw)) - cmd;
                    if (step < 0) step = -step;
                    if (err < 0) err = -err;
                    fire = step < 2 * tol && err < tol && it.aim_valid;
                end
                if (fire && !(fill != 0 && it.shot_speed == last_speed)) begin
                    speeds[head] = it.shot_speed;
                    head = (head + 1) % WIN_DEPTH;
                    if (fill < WIN_DEPTH) fill++;
                    last_speed = it.shot_speed;
                end
                prev_cmd = cmd;
            end
            sum = 0;
            for (int i = 0; i < fill; i++) sum += speeds[i];
            exp_item.fire = fire;
            exp_item.spin_mode = spinning;
            exp_item.mean_speed = (fill == 0) ? 16'd0 : 16'(sum / fill);
            expected[n_noted % EXP_SLOTS] = exp_item;
            n_noted++;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (n_noted == n_checked) begin
                report("result with nothing expected");
                return;
            end
            want = expected[n_checked % EXP_SLOTS];
            n_checked++;
            if (got.fire !== want.fire)
                report($sformatf("fire got %0b want %0b", got.fire, want.fire));
            if (got.spin_mode !== want.spin_mode)
                report($sformatf("spin_mode got %0b want %0b", got.spin_mode, want.spin_mode));
            if (got.mean_speed !== want.mean_speed)
                report($sformatf("mean_speed got %0d want %0d", got.mean_speed, want.mean_speed));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          cycles;
    int          results_seen;
    bit          no_idle;
    bit          held_off;
    int          last_cmd;
    fire_scoreboard sb;

    fgsh_in_if  in_ch();
    fgsh_out_if out_ch();

    fire_gate_with_spin_hysteresis_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function int idle_gap();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    task send_frame(t_in_item it);
        int gap;
        bit acc;
        gap = idle_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do begin
            @(negedge i_clk);
            acc = in_ch.valid && in_ch.ready;
            if (acc) sb.note_frame(it);
            @(posedge i_clk);
        end while (!acc);
    endtask

    task write_reg(t_reg_idx idx, bit [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task load_config(bit [15:0] near_t, bit [15:0] far_t, bit [15:0] judge, bit [15:0] af,
                     bit [15:0] enter, bit [15:0] leave, bit [15:0] rmin, bit [15:0] rmax);
        wait_drained();
        write_reg(REG_NEAR_TOL, near_t);
        write_reg(REG_FAR_TOL, far_t);
        write_reg(REG_JUDGE_RANGE, judge);
        write_reg(REG_AUTO_FIRE, af);
        write_reg(REG_SPIN_ENTER, enter);
        write_reg(REG_SPIN_EXIT, leave);
        write_reg(REG_RATIO_MIN, rmin);
        write_reg(REG_RATIO_MAX, rmax);
        i_cfg_we <= 1'b0;
    endtask

    function t_in_item rand_frame();
        t_in_item     it;
        logic [191:0] bits;
        int sel;
        int ctr;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = bits[$bits(t_in_item)-1:0];
        it.control_on = ($urandom_range(0, 99) < 92);
        it.target_present = ($urandom_range(0, 99) < 92);
        sel = $urandom_range(0, 9);
        if (sel < 3) it.spin_rate = 16'($signed($urandom_range(0, 1200)) - 600);
        else if (sel < 6) it.spin_rate = ($urandom_range(0, 1) ? 16'sd1 : -16'sd1) *
                                         16'($urandom_range(600, 5000));
        else if (sel == 6) it.spin_rate = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        if ($urandom_range(0, 99) < 70) begin
            it.pos_x_mm = 16'($signed($urandom_range(0, 16000)) - 8000);
            it.pos_y_mm = 16'($signed($urandom_range(0, 16000)) - 8000);
        end
        if ($urandom_range(0, 99) < 85) it.flight_time = 16'($urandom_range(1, 3000));
        it.armor_count = $urandom_range(0, 99) < 80 ? 3'($urandom_range(1, 4)) : 3'($urandom);
        if ($urandom_range(0, 99) < 70) begin
            ctr = sb.centre_angle($signed(it.pos_x_mm), $signed(it.pos_y_mm));
            for (int i = 0; i < LANES; i++)
                it.armor_yaws[16*i +: 16] = 16'(ctr + $signed($urandom_range(0, 6000)) - 3000);
        end
        if ($urandom_range(0, 99) < 70) begin
            it.cmd_yaw = 16'(last_cmd + $signed($urandom_range(0, 4000)) - 2000);
            it.gimbal_yaw = 16'($signed(it.cmd_yaw) + $signed($urandom_range(0, 4000)) - 2000);
        end
        if ($urandom_range(0, 99) < 60) it.shot_speed = 16'(7000 + 100 * $urandom_range(0, 3));
        it.aim_valid = ($urandom_range(0, 99) < 80);
        return it;
    endfunction

    task send_random(int n);
        t_in_item it;
        for (int k = 0; k < n; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            it = rand_frame();
            if (it.control_on && it.target_present) last_cmd = $signed(it.cmd_yaw);
            send_frame(it);
        end
        no_idle = 0;
    endtask

    task send_directed();
        t_in_item it;
        t_in_item base;
        base = '0;
        base.control_on = 1'b1;
        base.target_present = 1'b1;
        base.pos_x_mm = 16'sd1000;
        base.flight_time = 16'd500;
        base.aim_valid = 1'b1;
        base.shot_speed = 16'd7680;
        base.armor_count = 3'd4;
        it = base; it.control_on = 1'b0; send_frame(it);
        it = base; it.target_present = 1'b0; send_frame(it);
        it = base; send_frame(it);
        it = base; it.shot_speed = 16'hffff; it.cmd_yaw = 16'sd100; send_frame(it);
        it = base; it.cmd_yaw = 16'h7fff; it.gimbal_yaw = 16'h8000; send_frame(it);
        it = base; it.aim_valid = 1'b0; send_frame(it);
        it = base; it.pos_x_mm = 16'h8000; it.pos_y_mm = 16'h8000; it.shot_speed = 16'd0;
        send_frame(it);
        it = base; it.spin_rate = 16'h8000; it.armor_yaws = 64'h0000_0000_0100_ff00;
        send_frame(it);
        it = base; it.spin_rate = 16'sd3000; it.flight_time = 16'd0; send_frame(it);
        it = base; it.spin_rate = 16'sd3000; it.armor_count = 3'd0; send_frame(it);
        it = base; it.spin_rate = 16'sd3000; it.armor_count = 3'd7;
        it.armor_yaws = 64'hff00_ff00_ff00_ff00; send_frame(it);
        it = base; it.spin_rate = 16'sd0; it.armor_yaws = 64'h0100_ff00_0100_ff00;
        send_frame(it);
        it = base; it.spin_rate = -16'sd3000; it.pos_x_mm = -16'sd500; it.pos_y_mm = 16'sd0;
        it.armor_yaws = 64'h8000_7fff_c000_3000; it.flight_time = 16'hffff; send_frame(it);
        it = base; it.spin_rate = 16'sd3000; it.pos_x_mm = -16'sd500; it.pos_y_mm = -16'sd1;
        it.armor_yaws = 64'h1234_8000_7fff_0000; send_frame(it);
        it = base; it.spin_rate = 16'h7fff; it.pos_x_mm = 16'sd0; it.pos_y_mm = 16'sd0;
        it.armor_count = 3'd5; it.armor_yaws = 64'hffff_ffff_ffff_ffff; send_frame(it);
        for (int i = 0; i < 6; i++) begin
            it = base; it.spin_rate = 16'sd10; it.shot_speed = 16'(7000 + i); send_frame(it);
        end
        it = base; it.spin_rate = 16'sd1500; send_frame(it);
        it = base; it.spin_rate = -16'sd10; send_frame(it);
    endtask

    initial begin
        int gap;
        bit acc;
        forever begin
            if (results_seen == 60 && !held_off) begin
                held_off = 1;
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            gap = idle_gap();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do begin
                @(negedge i_clk);
                acc = out_ch.valid && out_ch.ready;
                if (acc) begin
                    sb.check_result(out_ch.data);
                    results_seen++;
                end
                @(posedge i_clk);
            end while (!acc);
        end
    end

    initial begin
        sb = new();
        cycles = 0;
        results_seen = 0;
        no_idle = 0;
        held_off = 0;
        last_cmd = 0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_random(4);
        load_config(16'd4000, 16'd2000, 16'd3000, 16'd1, 16'd2000, 16'd1000, 16'd0, 16'hffff);
        send_directed();
        send_random(150);
        load_config(16'h7fff, 16'h7fff, 16'h7fff, 16'd1, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
        send_random(110);
        load_config(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
        send_random(110);
        load_config(16'd3000, 16'd1500, 16'd5000, 16'd0, 16'd1000, 16'd500, 16'd0, 16'hffff);
        send_random(60);
        load_config(16'd1000, 16'd500, 16'd0, 16'd1, 16'd3000, 16'd2500, 16'd256, 16'd1024);
        send_random(140);
        load_config(16'd6000, 16'd300, 16'd6000, 16'd1, 16'd800, 16'd700, 16'd0, 16'd20000);
        send_random(140);
        wait_drained();
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
